// ===== src/format_string_formatter_defines.svh =====
// assertion macros for the format string formatter
`ifndef FORMAT_STRING_FORMATTER_DEFINES_SVH
`define FORMAT_STRING_FORMATTER_DEFINES_SVH

`ifndef ASSERT_OFF

// concurrent property checked on every rising clock edge outside reset
`define FSF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be true outside reset
`define FSF_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `FSF_ASSERT(lbl, clk, rst, !(cond), msg)

`else

`define FSF_ASSERT(lbl, clk, rst, prop, msg)
`define FSF_ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ===== src/fsf_pkg.sv =====
// types, constants and helpers shared by the format string formatter
`default_nettype none

package fsf_pkg;

   // magnitude register width, follows the 32-bit argument field
   localparam int MAG_W = 32;
   // ten decimal digits cover any 32-bit magnitude
   localparam int MAX_DIGITS = 10;
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   // q = (n * RECIP10) >> RECIP_SHIFT is exact for every 32-bit n
   localparam logic [MAG_W-1:0] RECIP10 = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT = 35;

   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_C     = 8'h63;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [3:0] TEN      = 4'd10;

   typedef enum logic [1:0] {
      MODE_TEXT,
      MODE_PCT,
      MODE_ERR
   } fsf_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_EMIT
   } fsf_state_type;

   typedef struct packed {
      logic [7:0]  fmt_char;
      logic [31:0] arg_value;
      logic        end_of_format;
   } fsf_req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       format_error;
      logic       run_last;
   } fsf_rsp_type;

   typedef struct packed {
      logic mul_en;
      logic decimal;
   } fsf_unit_ctrl_type;

   typedef struct packed {
      logic [MAG_W-1:0] quotient;
      logic [7:0]       digit_char;
      logic             last_digit;
   } fsf_unit_res_type;

   function automatic logic [7:0] digit_to_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < TEN) begin
         c = CH_ZERO + 8'(d);
      end else begin
         c = CH_A + 8'(d - TEN);
      end
      return c;
   endfunction

   function automatic fsf_rsp_type make_rsp(input logic [7:0] ch, input logic err,
                                            input logic last);
      fsf_rsp_type r;
      r.out_char     = ch;
      r.format_error = err;
      r.run_last     = last;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/fsf_digit_unit.sv =====
// shared digit step: one decimal or hex digit split off the magnitude
`default_nettype none

module fsf_digit_unit (
   input  wire logic                      clock,
   input  wire fsf_pkg::fsf_unit_ctrl_type ctrl,
   input  wire logic [fsf_pkg::MAG_W-1:0] mag,
   output fsf_pkg::fsf_unit_res_type      res
);

   logic [2*fsf_pkg::MAG_W-1:0] prod_ff;
   logic [2*fsf_pkg::MAG_W-1:0] prod_in;
   logic [fsf_pkg::MAG_W-1:0]   q_dec;
   logic [fsf_pkg::MAG_W-1:0]   q_hex;
   logic [fsf_pkg::MAG_W-1:0]   q_sel;
   logic [3:0]                  r_dec;
   logic [3:0]                  r_sel;

   // reciprocal product, registered in the cycle before the decimal step
   assign prod_in = ctrl.mul_en ? (2*fsf_pkg::MAG_W)'(mag) * (2*fsf_pkg::MAG_W)'(fsf_pkg::RECIP10)
                                : prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_comb begin
      q_dec = fsf_pkg::MAG_W'(prod_ff[2*fsf_pkg::MAG_W-1:fsf_pkg::RECIP_SHIFT]);
      q_hex = mag >> 4;
      // remainder below ten, so the low nibble of mag - 10*q is enough
      r_dec = mag[3:0] - {q_dec[0], 3'b000} - {q_dec[2:0], 1'b0};
      q_sel = ctrl.decimal ? q_dec : q_hex;
      r_sel = ctrl.decimal ? r_dec : mag[3:0];
      res.quotient   = q_sel;
      res.digit_char = fsf_pkg::digit_to_char(r_sel);
      res.last_digit = (q_sel == '0);
   end

endmodule

`default_nettype wire

// ===== src/format_string_formatter.sv =====
// top level of the streaming format string formatter (%d %x %c %%)
//
//   channel  ports              payload          direction
//   req      req_valid/stall    fsf_req_type     in, one format char per beat
//   rsp      rsp_valid/stall    fsf_rsp_type     out, one output char per beat
//
// plain characters, %c and %% go straight to the output register, with no conversion
// %x splits off one digit per ST_DIV step, %d one per ST_MUL (reciprocal multiply)
// then ST_DIV (digit split) step; ST_EMIT then sends the digits out, most significant first
// no new beat is taken while digits are converted or emitted
// rsp_stall holds the output register and, through it, the input side
// synchronous reset returns to idle in text mode with no output beat pending
`default_nettype none
`include "format_string_formatter_defines.svh"

module format_string_formatter #(
   parameter int ARG_WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire fsf_pkg::fsf_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output fsf_pkg::fsf_rsp_type      rsp_data
);

   // bits of the argument that the conversions see
   localparam int VW = (ARG_WIDTH < fsf_pkg::MAG_W) ? ARG_WIDTH : fsf_pkg::MAG_W;
   // beyond 32 bits the sign bit is always a zero extension
   localparam bit HAS_SIGN = (ARG_WIDTH <= fsf_pkg::MAG_W);

   fsf_pkg::fsf_state_type state_ff, state_in;
   fsf_pkg::fsf_mode_type  mode_ff, mode_in;
   logic [fsf_pkg::MAG_W-1:0] mag_ff, mag_in;
   logic                      dec_ff, dec_in;
   logic [fsf_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]                dig_ff [fsf_pkg::MAX_DIGITS];
   logic [7:0]                dig_in [fsf_pkg::MAX_DIGITS];
   fsf_pkg::fsf_rsp_type      rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   fsf_pkg::fsf_unit_ctrl_type unit_ctrl;
   fsf_pkg::fsf_unit_res_type  unit_res;

   logic          out_free;
   logic          req_fire;
   logic [7:0]    ch;
   logic          last;
   logic [VW-1:0] v_val;
   logic [VW-1:0] v_neg;
   logic          v_sign;
   logic          start_conv;
   logic          start_dec;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != fsf_pkg::ST_IDLE) || !out_free;
   assign req_fire  = req_valid && !req_stall;

   assign ch     = req_data.fmt_char;
   assign last   = req_data.end_of_format;
   assign v_val  = req_data.arg_value[VW-1:0];
   assign v_neg  = VW'(0) - v_val;
   assign v_sign = HAS_SIGN && v_val[VW-1];

   assign start_dec  = (mode_ff == fsf_pkg::MODE_PCT) && (ch == fsf_pkg::CH_D);
   assign start_conv = start_dec ||
                       ((mode_ff == fsf_pkg::MODE_PCT) && (ch == fsf_pkg::CH_X));

   fsf_digit_unit u_digit (
      .clock (clock),
      .ctrl  (unit_ctrl),
      .mag   (mag_ff),
      .res   (unit_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fsf_pkg::ST_IDLE: begin
            if (req_fire && start_conv) begin
               state_in = start_dec ? fsf_pkg::ST_MUL : fsf_pkg::ST_DIV;
            end
         end
         fsf_pkg::ST_MUL: begin
            state_in = fsf_pkg::ST_DIV;
         end
         fsf_pkg::ST_DIV: begin
            if (unit_res.last_digit) begin
               state_in = fsf_pkg::ST_EMIT;
            end else begin
               state_in = dec_ff ? fsf_pkg::ST_MUL : fsf_pkg::ST_DIV;
            end
         end
         fsf_pkg::ST_EMIT: begin
            if (out_free && (cnt_ff == fsf_pkg::CNT_W'(1))) begin
               state_in = fsf_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // datapath and output register
   always_comb begin
      mode_in      = mode_ff;
      mag_in       = mag_ff;
      dec_in       = dec_ff;
      cnt_in       = cnt_ff;
      dig_in       = dig_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unit_ctrl    = '0;
      unique case (state_ff)
         fsf_pkg::ST_IDLE: begin
            if (req_fire) begin
               cnt_in = '0;
               unique case (mode_ff)
                  fsf_pkg::MODE_ERR: begin
                     // dropping the rest of the format
                  end
                  fsf_pkg::MODE_PCT: begin
                     mode_in = fsf_pkg::MODE_TEXT;
                     priority if (ch == fsf_pkg::CH_PCT) begin
                        rsp_in       = fsf_pkg::make_rsp(fsf_pkg::CH_PCT, 1'b0, 1'b1);
                        rsp_valid_in = 1'b1;
                     end else if (ch == fsf_pkg::CH_D) begin
                        dec_in = 1'b1;
                        mag_in = v_sign ? fsf_pkg::MAG_W'(v_neg) : fsf_pkg::MAG_W'(v_val);
                        if (v_sign) begin
                           rsp_in       = fsf_pkg::make_rsp(fsf_pkg::CH_MINUS, 1'b0, 1'b0);
                           rsp_valid_in = 1'b1;
                        end
                     end else if (ch == fsf_pkg::CH_X) begin
                        dec_in = 1'b0;
                        mag_in = fsf_pkg::MAG_W'(v_val);
                     end else if (ch == fsf_pkg::CH_C) begin
                        rsp_in       = fsf_pkg::make_rsp(req_data.arg_value[7:0], 1'b0, 1'b1);
                        rsp_valid_in = 1'b1;
                     end else begin
                        rsp_in       = fsf_pkg::make_rsp(8'h00, 1'b1, 1'b1);
                        rsp_valid_in = 1'b1;
                        mode_in      = fsf_pkg::MODE_ERR;
                     end
                  end
                  default: begin
                     // a lone trailing percent goes out as text
                     if ((ch == fsf_pkg::CH_PCT) && !last) begin
                        mode_in = fsf_pkg::MODE_PCT;
                     end else begin
                        rsp_in       = fsf_pkg::make_rsp(ch, 1'b0, 1'b1);
                        rsp_valid_in = 1'b1;
                     end
                  end
               endcase
               if (last) begin
                  mode_in = fsf_pkg::MODE_TEXT;
               end
            end
         end
         fsf_pkg::ST_MUL: begin
            unit_ctrl.mul_en  = 1'b1;
            unit_ctrl.decimal = dec_ff;
         end
         fsf_pkg::ST_DIV: begin
            unit_ctrl.decimal = dec_ff;
            // digits come out least significant first, stack them
            dig_in[0] = unit_res.digit_char;
            for (int i = 1; i < fsf_pkg::MAX_DIGITS; i++) begin
               dig_in[i] = dig_ff[i-1];
            end
            cnt_in = cnt_ff + fsf_pkg::CNT_W'(1);
            mag_in = unit_res.quotient;
         end
         fsf_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_in = fsf_pkg::make_rsp(dig_ff[0], 1'b0, cnt_ff == fsf_pkg::CNT_W'(1));
               rsp_valid_in = 1'b1;
               for (int i = 0; i < fsf_pkg::MAX_DIGITS - 1; i++) begin
                  dig_in[i] = dig_ff[i+1];
               end
               cnt_in = cnt_ff - fsf_pkg::CNT_W'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fsf_pkg::ST_IDLE;
         mode_ff      <= fsf_pkg::MODE_TEXT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      dec_ff <= dec_in;
      dig_ff <= dig_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `FSF_ASSERT_NEVER(a_cnt_bound, clock, reset,
      cnt_ff > fsf_pkg::CNT_W'(fsf_pkg::MAX_DIGITS), "digit stack overflow")
   `FSF_ASSERT_NEVER(a_emit_nonempty, clock, reset,
      (state_ff == fsf_pkg::ST_EMIT) && (cnt_ff == '0), "emit with empty digit stack")
   `FSF_ASSERT(a_emit_done, clock, reset,
      ((state_ff == fsf_pkg::ST_EMIT) && out_free && (cnt_ff == fsf_pkg::CNT_W'(1)))
         |=> (state_ff == fsf_pkg::ST_IDLE) && rsp_valid_ff && rsp_ff.run_last,
      "last digit beat not closing the run")
   `FSF_ASSERT(a_err_last, clock, reset,
      (rsp_valid_ff && rsp_ff.format_error) |-> (rsp_ff.run_last && (rsp_ff.out_char == 8'h00)),
      "error beat malformed")

endmodule

`default_nettype wire
